@@ rtl/hrpf_pkg.sv @@
// ----------------------------------------------------------------------------
// hrpf_pkg
// Shared constants and types of the HTTP request packet filter: frame offsets,
// header field values, method text table and the frame view between stages.
// ----------------------------------------------------------------------------
package hrpf_pkg;

  localparam int PREFIX_BYTES_DEF    = 7;
  localparam int MAX_FRAME_BYTES_DEF = 65535;

  // Frame layout: Ethernet, 20-byte IPv4 header without options, TCP header
  localparam int ETH_LEN          = 14;
  localparam int ETHERTYPE_HI_POS = 12;
  localparam int ETHERTYPE_LO_POS = 13;
  localparam int IP_PROTO_POS     = ETH_LEN + 9;
  localparam int TCP_START        = 34;
  localparam int TCP_HDR_BYTES    = 20;
  localparam int TCP_END          = TCP_START + TCP_HDR_BYTES;
  localparam int HDR_IDX_W        = $clog2(TCP_HDR_BYTES);
  localparam int TCP_DOFF_IDX     = 12;
  localparam int TCP_FLAGS_IDX    = 13;
  localparam int TCP_PSH_BIT      = 3;

  localparam logic [7:0] ETHERTYPE_HI = 8'h08;
  localparam logic [7:0] ETHERTYPE_LO = 8'h00;
  localparam logic [7:0] IP_PROTO_TCP = 8'h06;

  // Method text, first character at index 0
  localparam int MATCH_BYTES = 6;
  localparam int NUM_METHODS = 6;

  typedef logic [MATCH_BYTES-1:0][7:0] method_text_t;
  typedef logic [TCP_HDR_BYTES-1:0][7:0] tcp_hdr_t;

  localparam method_text_t METHOD_TEXT [NUM_METHODS] = '{
    '{8'h00, 8'h00, "P", "T", "T", "H"},
    '{8'h00, 8'h00, 8'h00, "T", "E", "G"},
    '{8'h00, 8'h00, "T", "S", "O", "P"},
    '{8'h00, 8'h00, 8'h00, "T", "U", "P"},
    '{"E", "T", "E", "L", "E", "D"},
    '{8'h00, 8'h00, "D", "A", "E", "H"}
  };
  localparam int METHOD_LEN [NUM_METHODS] = '{4, 3, 4, 3, 6, 4};

  typedef struct packed {
    logic     type_ok;
    tcp_hdr_t tcp_hdr;
  } frame_view_t;

endpackage

@@ rtl/http_request_packet_filter.sv @@
// ----------------------------------------------------------------------------
// http_request_packet_filter
// Keeps Ethernet/IPv4/TCP frames with PSH set whose payload starts with an
// HTTP method or response line; gives one keep/drop item per frame.
// ----------------------------------------------------------------------------
// Input channel: one frame byte per item (in_data_byte) with in_last_byte on
// the final byte. Result channel: one item (out_keep) per frame, produced by
// its last byte; no item for the other bytes.
// Throughput: one byte per cycle while in_stall is low, frames back to back with no gap.
// Path: the last byte passes the input register and byte capture, then the
// decision stage, then the result register, which drives out_valid.
// Bytes past MAX_FRAME_BYTES are ignored and the length stays at that limit.
// Reset (rst_n low, synchronous) empties the input register, the decision
// stage and the result register and starts a new frame at byte zero.
// When out_stall holds a full result register with a second decision waiting,
// in_stall rises once a byte sits in the input register and input bytes wait;
// a stalled result register alone does not stop the input.
// ----------------------------------------------------------------------------
module http_request_packet_filter #(
  parameter int PREFIX_BYTES    = hrpf_pkg::PREFIX_BYTES_DEF,
  parameter int MAX_FRAME_BYTES = hrpf_pkg::MAX_FRAME_BYTES_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_data_byte,
  input  logic       in_last_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_keep
);

  localparam int POS_W = $clog2(MAX_FRAME_BYTES + 1);

  logic                          dec_ready;
  logic                          frame_done;
  logic [POS_W-1:0]              frame_len;
  hrpf_pkg::frame_view_t         view;
  logic [PREFIX_BYTES-1:0][7:0]  prefix;

  hrpf_capture #(
    .PREFIX_BYTES    (PREFIX_BYTES),
    .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
  ) u_capture (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data_byte (in_data_byte),
    .in_last_byte (in_last_byte),
    .dec_ready    (dec_ready),
    .frame_done   (frame_done),
    .frame_len    (frame_len),
    .view         (view),
    .prefix       (prefix)
  );

  hrpf_decide #(
    .PREFIX_BYTES    (PREFIX_BYTES),
    .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
  ) u_decide (
    .clk        (clk),
    .rst_n      (rst_n),
    .frame_done (frame_done),
    .frame_len  (frame_len),
    .view       (view),
    .prefix     (prefix),
    .dec_ready  (dec_ready),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_keep   (out_keep)
  );

endmodule

@@ rtl/hrpf_capture.sv @@
// ----------------------------------------------------------------------------
// hrpf_capture
// Input register and byte capture: position counter, ethertype/protocol check,
// TCP header store and payload prefix store.
// ----------------------------------------------------------------------------
module hrpf_capture #(
  parameter int PREFIX_BYTES    = hrpf_pkg::PREFIX_BYTES_DEF,
  parameter int MAX_FRAME_BYTES = hrpf_pkg::MAX_FRAME_BYTES_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic [7:0]                             in_data_byte,
  input  logic                                   in_last_byte,
  input  logic                                   dec_ready,
  output logic                                   frame_done,
  output logic [$clog2(MAX_FRAME_BYTES+1)-1:0]   frame_len,
  output hrpf_pkg::frame_view_t                  view,
  output logic [PREFIX_BYTES-1:0][7:0]           prefix
);

  localparam int POS_W  = $clog2(MAX_FRAME_BYTES + 1);
  localparam int PIDX_W = $clog2(PREFIX_BYTES);

  logic                 s1_valid_r;
  logic [7:0]           s1_data_r;
  logic                 s1_last_r;
  logic [POS_W-1:0]     pos_r;
  logic                 type_ok_r;
  hrpf_pkg::tcp_hdr_t   hdr_r;
  logic [PREFIX_BYTES-1:0][7:0] prefix_r;

  logic                 s1_adv;
  logic                 in_acc;
  logic                 pos_open;
  logic [POS_W-1:0]     pos_inc;
  logic [POS_W-1:0]     hdr_idx;
  logic [POS_W-1:0]     pay_off;
  logic [POS_W-1:0]     pay_rel;
  logic                 in_hdr;
  logic                 in_prefix;

  assign s1_adv   = s1_valid_r && dec_ready;
  assign in_stall = s1_valid_r && !dec_ready;
  assign in_acc   = in_valid && !in_stall;

  // counter saturates; bytes past the limit are ignored
  assign pos_open = pos_r < POS_W'(MAX_FRAME_BYTES);
  assign pos_inc  = pos_r + POS_W'(1);

  assign hdr_idx  = pos_r - POS_W'(hrpf_pkg::TCP_START);
  assign pay_off  = POS_W'(hrpf_pkg::TCP_START)
                  + POS_W'({hdr_r[hrpf_pkg::TCP_DOFF_IDX][7:4], 2'b00});
  assign pay_rel  = pos_r - pay_off;

  assign in_hdr    = (pos_r >= POS_W'(hrpf_pkg::TCP_START))
                  && (pos_r < POS_W'(hrpf_pkg::TCP_END));
  assign in_prefix = (pos_r >= POS_W'(hrpf_pkg::TCP_END)) && (pos_r >= pay_off)
                  && (pay_rel < POS_W'(PREFIX_BYTES));

  assign frame_done   = s1_adv && s1_last_r;
  assign frame_len    = pos_open ? pos_inc : pos_r;
  assign view.type_ok = type_ok_r;
  assign view.tcp_hdr = hdr_r;
  assign prefix       = prefix_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      pos_r      <= '0;
      type_ok_r  <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_adv) begin
        if (s1_last_r) begin
          pos_r <= '0;
        end else if (pos_open) begin
          pos_r <= pos_inc;
        end
        if (pos_open) begin
          if (pos_r == POS_W'(hrpf_pkg::ETHERTYPE_HI_POS)) begin
            type_ok_r <= (s1_data_r == hrpf_pkg::ETHERTYPE_HI);
          end else if (pos_r == POS_W'(hrpf_pkg::ETHERTYPE_LO_POS)) begin
            type_ok_r <= type_ok_r && (s1_data_r == hrpf_pkg::ETHERTYPE_LO);
          end else if (pos_r == POS_W'(hrpf_pkg::IP_PROTO_POS)) begin
            type_ok_r <= type_ok_r && (s1_data_r == hrpf_pkg::IP_PROTO_TCP);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_data_r <= in_data_byte;
      s1_last_r <= in_last_byte;
    end
    if (s1_adv && pos_open) begin
      if (in_hdr) begin
        hdr_r[hdr_idx[hrpf_pkg::HDR_IDX_W-1:0]] <= s1_data_r;
      end else if (in_prefix) begin
        prefix_r[pay_rel[PIDX_W-1:0]] <= s1_data_r;
      end
    end
  end

endmodule

@@ rtl/hrpf_decide.sv @@
// ----------------------------------------------------------------------------
// hrpf_decide
// Decision stage and result register: header checks, payload offset check and
// method prefix match over the captured bytes of a finished frame.
// ----------------------------------------------------------------------------
module hrpf_decide #(
  parameter int PREFIX_BYTES    = hrpf_pkg::PREFIX_BYTES_DEF,
  parameter int MAX_FRAME_BYTES = hrpf_pkg::MAX_FRAME_BYTES_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 frame_done,
  input  logic [$clog2(MAX_FRAME_BYTES+1)-1:0] frame_len,
  input  hrpf_pkg::frame_view_t                view,
  input  logic [PREFIX_BYTES-1:0][7:0]         prefix,
  output logic                                 dec_ready,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic                                 out_keep
);

  localparam int POS_W     = $clog2(MAX_FRAME_BYTES + 1);
  localparam int HDR_CASES = hrpf_pkg::TCP_HDR_BYTES / 4;

  logic                 d_valid_r;
  logic [POS_W-1:0]     len_r;
  logic                 out_valid_r;
  logic                 keep_r;

  logic                 out_ready;
  logic                 keep_c;
  logic                 hdr_ok;
  logic [3:0]           doff;
  logic [POS_W-1:0]     off;
  logic [hrpf_pkg::MATCH_BYTES-1:0][7:0] pbyte;
  logic [hrpf_pkg::MATCH_BYTES-1:0]      pin;
  logic [hrpf_pkg::NUM_METHODS-1:0]      hit;

  always_comb begin
    doff = view.tcp_hdr[hrpf_pkg::TCP_DOFF_IDX][7:4];
    off  = POS_W'(hrpf_pkg::TCP_START) + POS_W'({doff, 2'b00});

    // a small data offset puts the payload start inside the TCP header
    for (int i = 0; i < hrpf_pkg::MATCH_BYTES; i++) begin
      pbyte[i] = prefix[i];
      for (int k = 0; k < HDR_CASES; k++) begin
        if ((4 * k + i < hrpf_pkg::TCP_HDR_BYTES) && (doff == 4'(k))) begin
          pbyte[i] = view.tcp_hdr[4 * k + i];
        end
      end
      pin[i] = (off + POS_W'(i)) < len_r;
    end

    // method chars are never NUL, so a byte match also rules out a NUL before it
    for (int m = 0; m < hrpf_pkg::NUM_METHODS; m++) begin
      hit[m] = 1'b1;
      for (int i = 0; i < hrpf_pkg::MATCH_BYTES; i++) begin
        if ((i < hrpf_pkg::METHOD_LEN[m])
            && !(pin[i] && (pbyte[i] == hrpf_pkg::METHOD_TEXT[m][i]))) begin
          hit[m] = 1'b0;
        end
      end
    end

    hdr_ok = (len_r >= POS_W'(hrpf_pkg::TCP_END)) && view.type_ok
          && view.tcp_hdr[hrpf_pkg::TCP_FLAGS_IDX][hrpf_pkg::TCP_PSH_BIT]
          && (off <= len_r);
    keep_c = hdr_ok && (|hit);
  end

  assign out_ready = !out_valid_r || !out_stall;
  assign dec_ready = !d_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_keep  = keep_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (dec_ready) begin
        d_valid_r <= frame_done;
      end
      if (out_ready) begin
        out_valid_r <= d_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (dec_ready && frame_done) begin
      len_r <= frame_len;
    end
    if (out_ready && d_valid_r) begin
      keep_r <= keep_c;
    end
  end

  a_pending_held: assert property (@(posedge clk) disable iff (!rst_n)
    d_valid_r && !out_ready |=> d_valid_r && $stable(len_r))
    else $error("pending decision lost while result stalled");

  a_done_when_ready: assert property (@(posedge clk) disable iff (!rst_n)
    frame_done |-> dec_ready)
    else $error("frame finished while decision stage blocked");

  a_result_moves: assert property (@(posedge clk) disable iff (!rst_n)
    d_valid_r && out_ready |=> out_valid_r && (keep_r == $past(keep_c)))
    else $error("decision not moved into result register");

  a_keep_needs_hdr: assert property (@(posedge clk) disable iff (!rst_n)
    d_valid_r && keep_c |-> (len_r >= POS_W'(hrpf_pkg::TCP_END)) && view.type_ok)
    else $error("keep given for short or non-TCP frame");

endmodule
